/* rtl/drlp_pkg.sv */
// shared types and constants of the decimal range list parser
// used by drlp_step and decimal_range_list_parser_core; no dependencies
`default_nettype none

package drlp_pkg;

    localparam int unsigned VALUE_W = 32;

    // values above this limit overflow on the next digit; at the limit, digits 6 to 9 overflow
    localparam logic [VALUE_W-1:0] OVF_LIMIT = 32'd429496729;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_SIX   = 8'h36;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        PH_FIRST         = 3'd0,
        PH_FIRST_DIGITS  = 3'd1,
        PH_BEFORE_DASH   = 3'd2,
        PH_SECOND        = 3'd3,
        PH_SECOND_DIGITS = 3'd4,
        PH_TRAILING      = 3'd5,
        PH_ERROR         = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_PARSING     = 2'd0,
        ST_ERROR       = 2'd1,
        ST_END_CLEAN   = 2'd2,
        ST_END_CORRUPT = 2'd3
    } status_t;

    typedef struct packed {
        phase_t               phase;
        logic [VALUE_W-1:0]   first_value;
        logic [VALUE_W-1:0]   second_value;
    } parse_state_t;

    typedef struct packed {
        logic                 range_ready;
        logic [VALUE_W-1:0]   range_start;
        logic [VALUE_W-1:0]   range_end;
        status_t              status;
    } parse_result_t;

endpackage

`default_nettype wire

/* rtl/decimal_range_list_parser_core.sv */
// decimal range list parser: each input byte is registered in the input register, then its
// result in the result register; throughput one byte per cycle while the result register
// drains; the input register and result register are parted by drlp_step, and the input side
// keeps taking bytes while the result register can drain
// reset (rst_n, asynchronous, active low) clears the valid flags and returns the parser
// to the expect-first-number phase with both values zero
// depends on drlp_pkg and drlp_step
`default_nettype none

module decimal_range_list_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [31:0] range_start, [63:32] range_end,
                                        // [65:64] status, [71:66] zero
    output logic             m_tuser    // [0] range_ready
);

    logic                    in_valid_reg;
    logic                    in_kind_reg;
    logic [7:0]              in_byte_reg;
    drlp_pkg::parse_state_t  state_reg;
    drlp_pkg::parse_state_t  state_next;
    drlp_pkg::parse_result_t res_next;
    drlp_pkg::parse_result_t res_reg;
    logic                    out_valid_reg;
    logic                    out_free;
    logic                    fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    drlp_step u_step (
        .kind      (in_kind_reg),
        .data_byte (in_byte_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= drlp_pkg::PH_FIRST;
            state_reg.first_value  <= '0;
            state_reg.second_value <= '0;
            out_valid_reg          <= 1'b0;
        end
        else if (fire)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.range_ready;
    assign m_tdata  = {6'b0, res_reg.status, res_reg.range_end, res_reg.range_start};

    // a completed range is only reported while parsing
    a_range_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[65:64] == drlp_pkg::ST_PARSING))
        else $error("range reported with non-parsing status");

    // no range means both value fields read zero
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[63:0] == 64'd0))
        else $error("range fields nonzero without a range");

    // end of stream returns the parser to its reset phase
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_kind_reg == drlp_pkg::KIND_END)) |=>
        ((state_reg.phase == drlp_pkg::PH_FIRST) && (state_reg.first_value == '0)))
        else $error("end of stream did not reset parser");

    // the error phase is sticky for text bytes
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_kind_reg == drlp_pkg::KIND_BYTE) &&
         (state_reg.phase == drlp_pkg::PH_ERROR)) |=>
        ((state_reg.phase == drlp_pkg::PH_ERROR) && out_valid_reg &&
         (res_reg.status == drlp_pkg::ST_ERROR)))
        else $error("error phase left on a text byte");

    // state only moves when a result is written
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("parser state changed without a transaction");

endmodule

`default_nettype wire

/* rtl/drlp_step.sv */
// per-byte next-state and result logic of the range list parser
// depends on drlp_pkg
`default_nettype none

module drlp_step (
    input  wire logic                   kind,
    input  wire logic [7:0]             data_byte,
    input  wire drlp_pkg::parse_state_t cur,
    output drlp_pkg::parse_state_t      nxt,
    output drlp_pkg::parse_result_t     res
);

    logic                          is_digit;
    logic                          is_lead;
    logic                          is_eol;
    logic                          is_space;
    logic                          is_dash;
    logic [drlp_pkg::VALUE_W-1:0]  digit_val;
    logic [drlp_pkg::VALUE_W-1:0]  acc_src;
    logic                          acc_ok;
    logic [drlp_pkg::VALUE_W-1:0]  acc_val;

    assign is_digit  = (data_byte >= drlp_pkg::CHAR_ZERO) && (data_byte <= drlp_pkg::CHAR_NINE);
    assign is_lead   = (data_byte >= drlp_pkg::CHAR_ONE) && (data_byte <= drlp_pkg::CHAR_NINE);
    assign is_eol    = (data_byte == drlp_pkg::CHAR_CR) || (data_byte == drlp_pkg::CHAR_LF);
    assign is_space  = (data_byte == drlp_pkg::CHAR_SPACE);
    assign is_dash   = (data_byte == drlp_pkg::CHAR_DASH);
    assign digit_val = {{(drlp_pkg::VALUE_W-4){1'b0}}, data_byte[3:0]};

    // one shared accumulator: times ten as two shifts plus the digit
    assign acc_src = (cur.phase == drlp_pkg::PH_SECOND_DIGITS) ? cur.second_value
                                                                : cur.first_value;
    assign acc_ok  = (acc_src < drlp_pkg::OVF_LIMIT) ||
                     ((acc_src == drlp_pkg::OVF_LIMIT) && (data_byte < drlp_pkg::CHAR_SIX));
    assign acc_val = (acc_src << 3) + (acc_src << 1) + digit_val;

    always_comb
    begin
        nxt = cur;
        res.range_ready = 1'b0;
        res.range_start = '0;
        res.range_end   = '0;
        res.status      = drlp_pkg::ST_PARSING;

        if (kind == drlp_pkg::KIND_END)
        begin
            res.status = ((cur.phase == drlp_pkg::PH_FIRST) ||
                          (cur.phase == drlp_pkg::PH_TRAILING)) ? drlp_pkg::ST_END_CLEAN
                                                               : drlp_pkg::ST_END_CORRUPT;
            nxt.phase        = drlp_pkg::PH_FIRST;
            nxt.first_value  = '0;
            nxt.second_value = '0;
        end
        else
        begin
            unique case (cur.phase)
                drlp_pkg::PH_FIRST:
                begin
                    if (is_lead)
                    begin
                        nxt.first_value = digit_val;
                        nxt.phase       = drlp_pkg::PH_FIRST_DIGITS;
                    end
                    else if (!(is_space || is_eol))
                        nxt.phase = drlp_pkg::PH_ERROR;
                end
                drlp_pkg::PH_FIRST_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (acc_ok)
                            nxt.first_value = acc_val;
                        else
                            nxt.phase = drlp_pkg::PH_ERROR;
                    end
                    else if (is_space)
                        nxt.phase = drlp_pkg::PH_BEFORE_DASH;
                    else if (is_dash)
                        nxt.phase = drlp_pkg::PH_SECOND;
                    else
                        nxt.phase = drlp_pkg::PH_ERROR;
                end
                drlp_pkg::PH_BEFORE_DASH:
                begin
                    if (is_dash)
                        nxt.phase = drlp_pkg::PH_SECOND;
                    else if (!is_space)
                        nxt.phase = drlp_pkg::PH_ERROR;
                end
                drlp_pkg::PH_SECOND:
                begin
                    if (is_lead)
                    begin
                        nxt.second_value = digit_val;
                        nxt.phase        = drlp_pkg::PH_SECOND_DIGITS;
                    end
                    else if (!is_space)
                        nxt.phase = drlp_pkg::PH_ERROR;
                end
                drlp_pkg::PH_SECOND_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (acc_ok)
                            nxt.second_value = acc_val;
                        else
                            nxt.phase = drlp_pkg::PH_ERROR;
                    end
                    else if (is_space || is_eol)
                    begin
                        res.range_ready = 1'b1;
                        res.range_start = cur.first_value;
                        res.range_end   = cur.second_value;
                        nxt.phase = is_space ? drlp_pkg::PH_TRAILING : drlp_pkg::PH_FIRST;
                    end
                    else
                        nxt.phase = drlp_pkg::PH_ERROR;
                end
                drlp_pkg::PH_TRAILING:
                begin
                    if (is_eol)
                        nxt.phase = drlp_pkg::PH_FIRST;
                    else if (!is_space)
                        nxt.phase = drlp_pkg::PH_ERROR;
                end
                default:
                    nxt.phase = drlp_pkg::PH_ERROR;
            endcase
            res.status = (nxt.phase == drlp_pkg::PH_ERROR) ? drlp_pkg::ST_ERROR
                                                          : drlp_pkg::ST_PARSING;
        end
    end

endmodule

`default_nettype wire
